[src/assert_macros.svh]
// Assertion macros shared by the trie lookup core.
// Users must have clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle property, masked while reset is asserted.
`define BTP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define BTP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/btp_pkg.sv]
// Shared constants and types for the binary trie prefix lookup core.
// No dependencies.
package btp_pkg;

	localparam int ADDR_W    = 32;
	localparam int PLEN_W    = 6;
	localparam int DEPTH_W   = 6;
	localparam int FOUND_W   = 16;
	localparam int MAX_DEPTH = 32;

	localparam logic KIND_LOOKUP = 1'b0;
	localparam logic KIND_INSERT = 1'b1;

	// control for the address bit shifter
	typedef struct packed {
		logic load;
		logic shift;
	} shift_ctrl_t;

endpackage

[src/btp_node_mem.sv]
// Node memory of the trie: one write port, one registered read port.
// No package dependencies.
module btp_node_mem #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 41,
	parameter int AW    = 12
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

endmodule

[src/btp_addr_shift.sv]
// Address shifter: presents one address bit per trie level, MSB first.
// Depends on btp_pkg.
module btp_addr_shift (
	input  logic                      clk,
	input  btp_pkg::shift_ctrl_t      ctrl,
	input  logic [btp_pkg::ADDR_W-1:0] load_data,
	output logic                      msb
);

	logic [btp_pkg::ADDR_W-1:0] sr_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			sr_q <= load_data;
		end else if (ctrl.shift) begin
			sr_q <= {sr_q[btp_pkg::ADDR_W-2:0], 1'b0};
		end
	end

	assign msb = sr_q[btp_pkg::ADDR_W-1];

endmodule

[src/binary_trie_prefix_lookup_core.sv]
// Longest-prefix-match engine on a one-bit-per-level binary trie. A transfer on the input
// channel is either a lookup (kind 0) or a route insert (kind 1); every item yields exactly
// one result transfer. The address is consumed one bit per cycle from a shift register and
// every trie level costs one read of the node memory. A lookup walks down the trie and then
// responds; an insert walks along its (saturated) length as far as the trie goes, checks
// capacity, updates the deepest existing node and allocates a new node per missing level,
// while a refused insert goes to the response after the capacity check. The result then
// sits in the output register. One item is in flight at a time: in_stall is high from
// acceptance until the result has been moved into the output register, and a result still
// waiting there holds the next one back. The next input transfer can be accepted in the
// cycle after that move.
// The root node lives in flip-flops and is cleared by reset; all other nodes are written
// in full when allocated, so no clearing pass is needed and the block is ready right after
// reset. An insert that would need more nodes than remain returns table_full and changes
// nothing. Depends on btp_pkg, btp_node_mem, btp_addr_shift and assert_macros.svh.
`include "assert_macros.svh"

module binary_trie_prefix_lookup_core #(
	parameter int NODE_COUNT = 4096,
	parameter int PORT_BITS  = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// input channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        kind,
	input  logic [btp_pkg::ADDR_W-1:0]  address,
	input  logic [btp_pkg::PLEN_W-1:0]  prefix_len,
	input  logic [PORT_BITS-1:0]        port,
	// result channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        hit,
	output logic [btp_pkg::FOUND_W-1:0] found_port,
	output logic                        table_full
);

	localparam int IDX_W  = $clog2(NODE_COUNT);
	localparam int NF_W   = IDX_W + 1;
	localparam int SUM_W  = IDX_W + 2;
	localparam int ENT_W  = 2 * IDX_W + 1 + PORT_BITS;
	localparam int WIDE_W = (PORT_BITS > btp_pkg::FOUND_W) ? PORT_BITS : btp_pkg::FOUND_W;

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_WALK  = 3'd1;  // one trie level per cycle
	localparam logic [2:0] ST_CHECK = 3'd2;  // capacity check for insert
	localparam logic [2:0] ST_LINK  = 3'd3;  // update deepest existing node
	localparam logic [2:0] ST_ALLOC = 3'd4;  // write one new node per cycle
	localparam logic [2:0] ST_RESP  = 3'd5;  // hand result to output register

	logic [2:0]                  state_q;
	logic                        kind_q;
	logic [btp_pkg::PLEN_W-1:0]  plen_q;
	logic [PORT_BITS-1:0]        port_q;
	logic [btp_pkg::DEPTH_W-1:0] depth_q;
	logic [IDX_W-1:0]            cur_idx_q;
	logic [NF_W-1:0]             next_free_q;

	// copy of the node where the insert walk stopped
	logic [IDX_W-1:0]            par_zero_q;
	logic [IDX_W-1:0]            par_one_q;
	logic                        par_mark_q;
	logic [PORT_BITS-1:0]        par_port_q;

	// root node, kept in flops so reset can clear it
	logic [IDX_W-1:0]            root_zero_q;
	logic [IDX_W-1:0]            root_one_q;
	logic                        root_mark_q;
	logic [PORT_BITS-1:0]        root_port_q;

	// pending result
	logic                        res_hit_q;
	logic [PORT_BITS-1:0]        res_port_q;
	logic                        res_full_q;

	// output register
	logic                        out_valid_q;
	logic                        hit_q;
	logic [btp_pkg::FOUND_W-1:0] found_port_q;
	logic                        table_full_q;

	// node memory interface
	logic                        rd_en;
	logic [ENT_W-1:0]            rd_data;
	logic                        wr_en;
	logic [IDX_W-1:0]            wr_addr;
	logic [ENT_W-1:0]            wr_data;

	btp_pkg::shift_ctrl_t        sh_ctrl;
	logic                        addr_bit;

	// current node view
	logic [IDX_W-1:0]            node_zero;
	logic [IDX_W-1:0]            node_one;
	logic                        node_mark;
	logic [PORT_BITS-1:0]        node_port;
	logic [IDX_W-1:0]            child;
	logic [btp_pkg::DEPTH_W-1:0] limit;
	logic                        walk_stop;
	logic [btp_pkg::DEPTH_W-1:0] need;
	logic [SUM_W-1:0]            need_sum;
	logic                        no_room;
	logic [IDX_W-1:0]            nf_idx;
	logic [IDX_W-1:0]            nf_next;

	// node write fields
	logic                        wr_go;
	logic                        wr_root;
	logic [IDX_W-1:0]            w_zero;
	logic [IDX_W-1:0]            w_one;
	logic                        w_mark;
	logic [PORT_BITS-1:0]        w_port;

	logic                        accept;
	logic                        out_free;
	logic [WIDE_W-1:0]           res_port_wide;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	btp_node_mem #(
		.DEPTH (NODE_COUNT),
		.WIDTH (ENT_W),
		.AW    (IDX_W)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (child),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	assign sh_ctrl.load  = accept;
	assign sh_ctrl.shift = ((state_q == ST_WALK) && !walk_stop) ||
		(state_q == ST_LINK) || (state_q == ST_ALLOC);

	btp_addr_shift u_shift (
		.clk       (clk),
		.ctrl      (sh_ctrl),
		.load_data (address),
		.msb       (addr_bit)
	);

	// Node under inspection: root from flops, any other from the read register.
	always_comb begin
		if (cur_idx_q == '0) begin
			node_zero = root_zero_q;
			node_one  = root_one_q;
			node_mark = root_mark_q;
			node_port = root_port_q;
		end else begin
			{node_zero, node_one, node_mark, node_port} = rd_data;
		end
	end

	assign child     = addr_bit ? node_one : node_zero;
	assign limit     = (kind_q == btp_pkg::KIND_LOOKUP) ?
		btp_pkg::DEPTH_W'(btp_pkg::MAX_DEPTH) : plen_q;
	assign walk_stop = (depth_q >= limit) || (child == '0);
	assign rd_en     = (state_q == ST_WALK) && !walk_stop;

	assign need     = plen_q - depth_q;
	assign need_sum = SUM_W'(next_free_q) + SUM_W'(need);
	assign no_room  = need_sum > SUM_W'(NODE_COUNT);
	assign nf_idx   = next_free_q[IDX_W-1:0];
	assign nf_next  = nf_idx + IDX_W'(1);

	// Write data. LINK: mark the stop node, or hang the first new node under it.
	// ALLOC: a fresh node pointing at the next one, or the marked leaf.
	always_comb begin
		wr_go   = 1'b0;
		wr_root = 1'b0;
		wr_addr = cur_idx_q;
		w_zero  = '0;
		w_one   = '0;
		w_mark  = 1'b0;
		w_port  = '0;
		unique case (state_q)
			ST_LINK: begin
				wr_go   = 1'b1;
				wr_root = (cur_idx_q == '0);
				if (need == '0) begin
					w_zero = par_zero_q;
					w_one  = par_one_q;
					w_mark = 1'b1;
					w_port = port_q;
				end else begin
					w_zero = addr_bit ? par_zero_q : nf_idx;
					w_one  = addr_bit ? nf_idx : par_one_q;
					w_mark = par_mark_q;
					w_port = par_port_q;
				end
			end
			ST_ALLOC: begin
				wr_go   = 1'b1;
				wr_addr = nf_idx;
				if (depth_q == plen_q) begin
					w_mark = 1'b1;
					w_port = port_q;
				end else begin
					w_zero = addr_bit ? '0 : nf_next;
					w_one  = addr_bit ? nf_next : '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign wr_en   = wr_go && !wr_root;
	assign wr_data = {w_zero, w_one, w_mark, w_port};

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			next_free_q <= NF_W'(1);
			root_zero_q <= '0;
			root_one_q  <= '0;
			root_mark_q <= 1'b0;
			root_port_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_go && wr_root) begin
				root_zero_q <= w_zero;
				root_one_q  <= w_one;
				root_mark_q <= w_mark;
				root_port_q <= w_port;
			end

			if ((state_q == ST_RESP) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (walk_stop) begin
						state_q <= (kind_q == btp_pkg::KIND_LOOKUP) ? ST_RESP : ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= no_room ? ST_RESP : ST_LINK;
				end
				ST_LINK: begin
					state_q <= (need == '0) ? ST_RESP : ST_ALLOC;
				end
				ST_ALLOC: begin
					next_free_q <= next_free_q + NF_W'(1);
					if (depth_q == plen_q) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q     <= kind;
			plen_q     <= (prefix_len > btp_pkg::PLEN_W'(btp_pkg::MAX_DEPTH)) ?
				btp_pkg::PLEN_W'(btp_pkg::MAX_DEPTH) : prefix_len;
			port_q     <= port;
			depth_q    <= '0;
			cur_idx_q  <= '0;
			res_hit_q  <= 1'b0;
			res_port_q <= '0;
			res_full_q <= 1'b0;
		end

		if (state_q == ST_WALK) begin
			if ((kind_q == btp_pkg::KIND_LOOKUP) && node_mark) begin
				res_hit_q  <= 1'b1;
				res_port_q <= node_port;
			end
			if (walk_stop) begin
				par_zero_q <= node_zero;
				par_one_q  <= node_one;
				par_mark_q <= node_mark;
				par_port_q <= node_port;
			end else begin
				cur_idx_q <= child;
				depth_q   <= depth_q + btp_pkg::DEPTH_W'(1);
			end
		end

		if ((state_q == ST_CHECK) && no_room) begin
			res_full_q <= 1'b1;
		end

		if ((state_q == ST_LINK) || (state_q == ST_ALLOC)) begin
			depth_q <= depth_q + btp_pkg::DEPTH_W'(1);
		end

		if ((state_q == ST_RESP) && out_free) begin
			hit_q        <= res_hit_q;
			found_port_q <= res_port_wide[btp_pkg::FOUND_W-1:0];
			table_full_q <= res_full_q;
		end
	end

	assign res_port_wide = WIDE_W'(res_port_q);

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign found_port = found_port_q;
	assign table_full = table_full_q;

	// Checks
	`BTP_ASSERT(a_free_bound, next_free_q <= NF_W'(NODE_COUNT), "free counter past node count")
	`BTP_ASSERT_NEXT(a_accept_walk, accept, state_q == ST_WALK, "accepted item did not start walk")
	`BTP_ASSERT(a_walk_depth, (state_q == ST_WALK) |-> (depth_q <= btp_pkg::DEPTH_W'(btp_pkg::MAX_DEPTH)), "walk deeper than 32 levels")
	`BTP_ASSERT(a_alloc_not_root, (state_q == ST_ALLOC) |-> (nf_idx != '0), "allocation targets root")
	`BTP_ASSERT(a_result_kind, out_valid_q |-> !(hit_q && table_full_q), "hit and table_full together")

endmodule

[tb/sv/binary_trie_prefix_lookup_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for binary_trie_prefix_lookup_core: route inserts and address lookups
// are checked one by one against a behavioral trie kept inside the bench.
// Depends on btp_pkg and the core RTL.
module binary_trie_prefix_lookup_core_tb;

	localparam int NODES         = 4096;
	localparam int PBITS         = 16;
	localparam int HALF_PERIOD   = 6;
	localparam int DRAIN_CYCLES  = 40;
	localparam int HOLD_AT       = 150;       // result count that starts the long hold-off
	localparam int HOLD_CYCLES   = 300;
	localparam int MAX_REPORTS   = 10;
	localparam logic [btp_pkg::ADDR_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

	typedef struct {
		logic                       kind;
		logic [btp_pkg::ADDR_W-1:0] addr;
		logic [btp_pkg::PLEN_W-1:0] plen;
		logic [PBITS-1:0]           port;
	} route_req_t;

	typedef struct {
		logic                        hit;
		logic [btp_pkg::FOUND_W-1:0] fport;
		logic                        full;
	} route_resp_t;

	// a prefix that went into the table, kept so lookups can aim at it
	typedef struct {
		logic [btp_pkg::ADDR_W-1:0] addr;
		int unsigned                len;
	} route_t;

	// ---------------------------------------------------------------- DUT ports
	logic                        clk        = 1'b0;
	logic                        arst_n     = 1'b0;
	logic                        in_valid   = 1'b0;
	logic                        in_stall;
	logic                        kind       = btp_pkg::KIND_LOOKUP;
	logic [btp_pkg::ADDR_W-1:0]  address    = '0;
	logic [btp_pkg::PLEN_W-1:0]  prefix_len = '0;
	logic [PBITS-1:0]            port       = '0;
	logic                        out_valid;
	logic                        out_stall  = 1'b0;
	logic                        hit;
	logic [btp_pkg::FOUND_W-1:0] found_port;
	logic                        table_full;

	binary_trie_prefix_lookup_core #(
		.NODE_COUNT(NODES),
		.PORT_BITS (PBITS)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.address   (address),
		.prefix_len(prefix_len),
		.port      (port),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.hit       (hit),
		.found_port(found_port),
		.table_full(table_full)
	);

	always begin
		clk = 1'b1;
		#(HALF_PERIOD);
		clk = 1'b0;
		#(HALF_PERIOD);
	end

	// ---------------------------------------------------------------- bench state
	route_req_t  send_q[$];     // items waiting for the driver
	route_resp_t want_q[$];     // predicted results, oldest first
	route_t      routes[$];     // recent inserted prefixes
	int unsigned fail_cnt = 0;
	int unsigned res_cnt  = 0;

	// behavioral trie: node 0 is the root, child 0 means no child
	int unsigned      trie_zero[NODES];
	int unsigned      trie_one[NODES];
	bit               trie_mark[NODES];
	logic [PBITS-1:0] trie_port[NODES];
	int unsigned      trie_free;

	function automatic int unsigned trie_kid(int unsigned node, logic b);
		return b ? trie_one[node] : trie_zero[node];
	endfunction

	// Applies one item to the trie and returns the result the core should give.
	function automatic route_resp_t trie_apply(route_req_t rq);
		route_resp_t r;
		int unsigned node, c, depth, len, need;
		r     = '{hit: 1'b0, fport: '0, full: 1'b0};
		node  = 0;
		depth = 0;
		if (rq.kind == btp_pkg::KIND_LOOKUP) begin
			// deepest marked node on the path wins; the root counts (default route)
			for (int lvl = 0; lvl <= btp_pkg::MAX_DEPTH; lvl++) begin
				if (trie_mark[node]) begin
					r.hit   = 1'b1;
					r.fport = btp_pkg::FOUND_W'(trie_port[node]);
				end
				if (lvl == btp_pkg::MAX_DEPTH)
					break;
				c = trie_kid(node, rq.addr[btp_pkg::ADDR_W-1-lvl]);
				if (c == 0)
					break;
				node = c;
			end
		end else begin
			len = (rq.plen > btp_pkg::MAX_DEPTH) ? btp_pkg::MAX_DEPTH : rq.plen;
			while (depth < len) begin
				c = trie_kid(node, rq.addr[btp_pkg::ADDR_W-1-depth]);
				if (c == 0)
					break;
				node = c;
				depth++;
			end
			need = len - depth;
			// refused inserts leave the table untouched
			if (need > NODES - trie_free) begin
				r.full = 1'b1;
			end else begin
				while (depth < len) begin
					c = trie_free;
					trie_free++;
					trie_zero[c] = 0;
					trie_one[c]  = 0;
					trie_mark[c] = 1'b0;
					trie_port[c] = '0;
					if (rq.addr[btp_pkg::ADDR_W-1-depth])
						trie_one[node] = c;
					else
						trie_zero[node] = c;
					node = c;
					depth++;
				end
				trie_mark[node] = 1'b1;
				trie_port[node] = rq.port;
			end
		end
		return r;
	endfunction

	// ---------------------------------------------------------------- stimulus helpers
	// keeps the top len bits of base, randomizes the rest
	function automatic logic [btp_pkg::ADDR_W-1:0] keep_prefix(
			logic [btp_pkg::ADDR_W-1:0] base, int unsigned len);
		logic [btp_pkg::ADDR_W-1:0] low;
		low = (len >= btp_pkg::ADDR_W) ? '0 : (ALL_ONES >> len);
		return (base & ~low) | ($urandom() & low);
	endfunction

	task automatic post(logic k, logic [btp_pkg::ADDR_W-1:0] a,
			logic [btp_pkg::PLEN_W-1:0] pl, logic [PBITS-1:0] p);
		route_t rt;
		send_q.push_back('{k, a, pl, p});
		if (k == btp_pkg::KIND_INSERT) begin
			rt.addr = a;
			rt.len  = (pl > btp_pkg::MAX_DEPTH) ? btp_pkg::MAX_DEPTH : pl;
			routes.push_back(rt);
			if (routes.size() > 256)
				void'(routes.pop_front());
		end
	endtask

	// fill_pct: share of long random inserts, used to run the node memory dry
	task automatic post_random(int unsigned fill_pct);
		route_t      rt;
		int unsigned roll, pick, len;
		logic [btp_pkg::ADDR_W-1:0] a;
		if (routes.size() != 0)
			rt = routes[$urandom_range(0, routes.size() - 1)];
		else
			rt = '{addr: '0, len: 0};
		roll = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < fill_pct) begin
			post(btp_pkg::KIND_INSERT, $urandom(), 6'd32, PBITS'($urandom()));
		end else if (roll < 8) begin
			// overwrite the port of a known prefix
			post(btp_pkg::KIND_INSERT, rt.addr, btp_pkg::PLEN_W'(rt.len),
				PBITS'($urandom()));
		end else if (roll < 42) begin
			pick = $urandom_range(0, 19);
			if (pick < 2)
				len = $urandom_range(0, 7);
			else if (pick < 13)
				len = $urandom_range(8, 24);
			else if (pick < 18)
				len = $urandom_range(25, 32);
			else
				len = $urandom_range(33, 63);    // saturates to a host route
			if (roll < 25) begin
				a = keep_prefix(rt.addr, rt.len);   // nests under a known prefix
				if (len < rt.len)
					len = rt.len + $urandom_range(0, 8);
			end else begin
				a = $urandom();
			end
			post(btp_pkg::KIND_INSERT, a, btp_pkg::PLEN_W'(len), PBITS'($urandom()));
		end else if (roll < 50) begin
			post(btp_pkg::KIND_LOOKUP, rt.addr, btp_pkg::PLEN_W'($urandom()),
				PBITS'($urandom()));
		end else if (roll < 80) begin
			post(btp_pkg::KIND_LOOKUP, keep_prefix(rt.addr, rt.len),
				btp_pkg::PLEN_W'($urandom()), PBITS'($urandom()));
		end else begin
			post(btp_pkg::KIND_LOOKUP, $urandom(), btp_pkg::PLEN_W'($urandom()),
				PBITS'($urandom()));
		end
	endtask

	// everything sent and every result back
	task automatic wait_drained();
		while (send_q.size() != 0 || in_valid || want_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic log_mismatch(string what);
		fail_cnt++;
		if (fail_cnt <= MAX_REPORTS)
			$display("mismatch %0d at %0t ns: %s", fail_cnt, $time, what);
	endtask

	// ---------------------------------------------------------------- driver
	// In gap mode an idle gap of random length is drawn per transfer; every 50 transfers the
	// sender may switch to back-to-back mode. Payload only moves when not stalled.
	int unsigned send_gap;
	int unsigned send_cnt;
	bit          send_idle;

	always @(posedge clk or negedge arst_n) begin
		route_req_t  rq;
		int unsigned gap;
		if (!arst_n) begin
			in_valid   <= 1'b0;
			kind       <= btp_pkg::KIND_LOOKUP;
			address    <= '0;
			prefix_len <= '0;
			port       <= '0;
			send_gap   <= 0;
			send_cnt   <= 0;
			send_idle  <= 1'b1;
		end else if (!(in_valid && in_stall)) begin
			if (in_valid) begin
				// transfer done at this edge
				gap = send_idle ? $urandom_range(0, 4) : 0;
				send_cnt <= send_cnt + 1;
				if (send_cnt % 50 == 49)
					send_idle <= ($urandom_range(0, 2) != 0);
			end else begin
				gap = send_gap;
			end
			if (gap != 0 || send_q.size() == 0) begin
				in_valid <= 1'b0;
				send_gap <= (gap != 0) ? gap - 1 : 0;
			end else begin
				rq = send_q.pop_front();
				in_valid   <= 1'b1;
				kind       <= rq.kind;
				address    <= rq.addr;
				prefix_len <= rq.plen;
				port       <= rq.port;
				send_gap   <= 0;
			end
		end
	end

	// ---------------------------------------------------------------- receiver
	// A stall of random length after each result, with quiet stretches, plus one long
	// hold-off from its own counter so the core backs up and stalls its input.
	int unsigned stall_left;
	int unsigned take_cnt;
	bit          take_idle;
	int unsigned hold_left;
	bit          hold_done;

	always @(posedge clk or negedge arst_n) begin
		int unsigned n;
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
			take_cnt   <= 0;
			take_idle  <= 1'b1;
		end else begin
			if (out_valid && !out_stall) begin
				n = take_idle ? $urandom_range(0, 4) : 0;
				take_cnt <= take_cnt + 1;
				if (take_cnt % 40 == 39)
					take_idle <= ($urandom_range(0, 2) != 0);
			end else begin
				n = (stall_left != 0) ? stall_left - 1 : 0;
			end
			stall_left <= n;
			out_stall  <= (n != 0) || (hold_left != 0);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && res_cnt == HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// ---------------------------------------------------------------- monitor
	// Result side is checked before the input side is predicted, so a result can
	// never be matched against the item accepted at the same edge.
	always @(posedge clk) begin
		route_req_t  rq;
		route_resp_t w;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				res_cnt <= res_cnt + 1;
				if (want_q.size() == 0) begin
					log_mismatch($sformatf("result with nothing pending: hit=%0b port=%h full=%0b",
						hit, found_port, table_full));
				end else begin
					w = want_q.pop_front();
					if (hit !== w.hit || found_port !== w.fport || table_full !== w.full)
						log_mismatch($sformatf(
							"want hit=%0b port=%h full=%0b, got hit=%0b port=%h full=%0b",
							w.hit, w.fport, w.full, hit, found_port, table_full));
				end
			end
			if (in_valid && !in_stall) begin
				rq = '{kind, address, prefix_len, port};
				want_q.push_back(trie_apply(rq));
			end
		end
	end

	// ---------------------------------------------------------------- sequence
	initial begin
		for (int i = 0; i < NODES; i++) begin
			trie_zero[i] = 0;
			trie_one[i]  = 0;
			trie_mark[i] = 1'b0;
			trie_port[i] = '0;
		end
		trie_free = 1;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty table: both address extremes miss
		post(btp_pkg::KIND_LOOKUP, 32'h0000_0000, 6'd0, 16'h0000);
		post(btp_pkg::KIND_LOOKUP, ALL_ONES, 6'd63, 16'hFFFF);
		// nested prefixes, longest match must win
		post(btp_pkg::KIND_INSERT, 32'hC0A8_0000, 6'd16, 16'hFFFF);
		post(btp_pkg::KIND_INSERT, 32'hC0A8_0100, 6'd24, 16'h0001);
		post(btp_pkg::KIND_INSERT, 32'hC0A8_0101, 6'd32, 16'h8000);
		post(btp_pkg::KIND_LOOKUP, 32'hC0A8_0101, 6'd0, 16'h0000);
		post(btp_pkg::KIND_LOOKUP, 32'hC0A8_0102, 6'd0, 16'h0000);
		post(btp_pkg::KIND_LOOKUP, 32'hC0A8_FF00, 6'd0, 16'h0000);
		post(btp_pkg::KIND_LOOKUP, 32'h0A00_0000, 6'd0, 16'h0000);
		// default route then matches everything
		post(btp_pkg::KIND_INSERT, 32'h1234_5678, 6'd0, 16'h00AA);
		post(btp_pkg::KIND_LOOKUP, 32'h0A00_0000, 6'd0, 16'h0000);
		// reinsert overwrites the port
		post(btp_pkg::KIND_INSERT, 32'hC0A8_0100, 6'd24, 16'h5555);
		post(btp_pkg::KIND_LOOKUP, 32'hC0A8_01FE, 6'd0, 16'h0000);
		// all-ones host route with port zero still counts as a hit
		post(btp_pkg::KIND_INSERT, ALL_ONES, 6'd32, 16'h0000);
		post(btp_pkg::KIND_LOOKUP, ALL_ONES, 6'd0, 16'h0000);
		// lengths above 32 saturate
		post(btp_pkg::KIND_INSERT, 32'h0000_0000, 6'd63, 16'h7FFF);
		post(btp_pkg::KIND_LOOKUP, 32'h0000_0000, 6'd0, 16'h0000);
		post(btp_pkg::KIND_INSERT, 32'h8000_0001, 6'd33, 16'h0F0F);
		post(btp_pkg::KIND_LOOKUP, 32'h8000_0001, 6'd0, 16'h0000);
		post(btp_pkg::KIND_LOOKUP, 32'h8000_0000, 6'd0, 16'h0000);
		// bits below the prefix length are ignored on insert
		post(btp_pkg::KIND_INSERT, 32'h8FFF_FFFF, 6'd1, 16'h1111);
		post(btp_pkg::KIND_LOOKUP, 32'hF000_0000, 6'd0, 16'h0000);

		// mixed traffic; the long hold-off lands in here
		for (int i = 0; i < 650; i++)
			post_random(0);
		// sender pause: let every result come back before going on
		wait_drained();
		repeat ($urandom_range(5, 20)) @(negedge clk);
		// heavy host-route inserts run the node memory out
		for (int i = 0; i < 250; i++)
			post_random(60);
		// traffic against a full table
		for (int i = 0; i < 280; i++)
			post_random(0);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// watchdog: expected run is well under 1 ms
	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
